// ----- rtl/pfcg_pkg.sv -----
package pfcg_pkg;

  localparam int FracBitsDefault = 16;

  typedef enum logic [2:0] {
    REG_AXIS_X = 3'd0,
    REG_AXIS_Y = 3'd1,
    REG_AXIS_Z = 3'd2,
    REG_BASE_R = 3'd3,
    REG_TOP_R  = 3'd4,
    REG_HEIGHT = 3'd5,
    REG_COS    = 3'd6,
    REG_SIN    = 3'd7
  } reg_idx_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CONTACT = 1'b1;

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_ROW,
    OP_WD,
    OP_WA,
    OP_LOC,
    OP_WROT,
    OP_SQ,
    OP_SQRT,
    OP_UDIV,
    OP_D,
    OP_K_W,
    OP_N,
    OP_RH,
    OP_L,
    OP_C,
    OP_GAP
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WD,
    S_WA,
    S_LOC,
    S_WROT,
    S_SQ,
    S_SQRT,
    S_UDIV,
    S_D,
    S_KW,
    S_N,
    S_RH,
    S_L,
    S_C,
    S_GAP,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic start;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic oor;
    logic deg;
  } stat_t;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] r;
    r = x;
    if (x > 64'sd2147483647) r = 64'sd2147483647;
    if (x < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

endpackage

// ----- rtl/pfcg_datapath.sv -----
module pfcg_datapath #(
  parameter int FRAC_BITS = pfcg_pkg::FracBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  pfcg_pkg::cmd_t      cmd,
  output pfcg_pkg::stat_t     stat,
  input  logic [1:0]          row_index,
  input  logic signed [31:0]  value_a,
  input  logic signed [31:0]  value_b,
  input  logic signed [31:0]  value_c,
  input  logic signed [31:0]  frustum_x,
  input  logic signed [31:0]  frustum_y,
  input  logic signed [31:0]  frustum_z,
  input  logic signed [31:0]  axis_x,
  input  logic signed [31:0]  axis_y,
  input  logic signed [31:0]  axis_z,
  input  logic [30:0]         base_radius,
  input  logic [30:0]         top_radius,
  input  logic [30:0]         cone_height,
  input  logic signed [17:0]  cos_half_angle,
  input  logic signed [17:0]  sin_half_angle,
  output logic signed [31:0]  gap,
  output logic signed [31:0]  n_x,
  output logic signed [31:0]  n_y,
  output logic signed [31:0]  n_z
);
  import pfcg_pkg::*;

  localparam logic signed [63:0] One = 64'sd1 <<< FRAC_BITS;

  logic signed [31:0] rows [9];
  logic signed [31:0] wd [3];
  logic signed [31:0] wa [3];
  logic signed [31:0] wrot [3];
  logic signed [31:0] u [3];
  logic signed [31:0] w [3];
  logic signed [31:0] c [3];
  logic signed [31:0] loc, dreg, kreg, rh, lreg;
  logic [63:0] sq;
  logic oor, deg;

  // Shared iterative unit: 32-step root, 64-step quotient (three lanes of the
  // unit vector, then the radius slope term).
  logic [1:0]  lane;
  logic [6:0]  cnt;
  logic [63:0] rem, quo, divisor, num;
  logic [31:0] root;
  logic        quo_neg;
  logic        div_rh;
  logic        busy;

  function automatic logic signed [63:0] qm(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] s32(input logic signed [63:0] x);
    return 32'(sat32(x));
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  logic signed [31:0] axv [3];
  logic signed [31:0] pv [3];
  logic signed [31:0] fv [3];
  assign axv = '{axis_x, axis_y, axis_z};
  assign pv = '{value_a, value_b, value_c};
  assign fv = '{frustum_x, frustum_y, frustum_z};

  logic signed [31:0] ksub;
  assign ksub = s32(qm(32'(One - 64'(cos_half_angle)), dreg));

  logic [63:0] rt_try;
  logic [63:0] rem_shift;
  assign rem_shift = {rem[61:0], sq[63 - 2 * cnt[4:0] -: 2]};
  assign rt_try = {30'd0, root, 2'b01};

  logic [64:0] dv_try;
  assign dv_try = {rem, num[63]} - {1'b0, divisor};

  logic [63:0]        qlast;
  logic signed [63:0] qsigned;
  assign qlast = {quo[62:0], ~dv_try[64]};
  assign qsigned = quo_neg ? -$signed(qlast) : $signed(qlast);

  logic signed [31:0] rdiff;
  logic signed [63:0] rh_prod;
  assign rdiff = $signed({1'b0, top_radius}) - $signed({1'b0, base_radius});
  assign rh_prod = 64'(rdiff) * 64'(loc);

  assign stat.busy = busy;
  assign stat.oor = oor;
  assign stat.deg = deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) rows[i] <= '0;
      busy <= 1'b0;
      oor <= 1'b0;
      deg <= 1'b0;
    end else begin
      if (cmd.clr) begin
        oor <= 1'b0;
        deg <= 1'b0;
        gap <= '0;
        n_x <= '0;
        n_y <= '0;
        n_z <= '0;
      end
      case (cmd.op)
        OP_LOAD_ROW: begin
          if (row_index != 2'd3) begin
            for (int j = 0; j < 3; j++) rows[row_index * 3 + j] <= pv[j];
          end
        end
        OP_WD: for (int i = 0; i < 3; i++) wd[i] <= s32(64'(pv[i]) - 64'(fv[i]));
        OP_WA: for (int i = 0; i < 3; i++)
          wa[i] <= s32(qm(rows[i*3], axv[0]) + qm(rows[i*3+1], axv[1])
                       + qm(rows[i*3+2], axv[2]));
        OP_LOC: begin
          loc <= s32(qm(wd[0], wa[0]) + qm(wd[1], wa[1]) + qm(wd[2], wa[2]));
          if (s32(qm(wd[0], wa[0]) + qm(wd[1], wa[1]) + qm(wd[2], wa[2])) < 0 ||
              64'(s32(qm(wd[0], wa[0]) + qm(wd[1], wa[1]) + qm(wd[2], wa[2])))
              > 64'($signed({1'b0, cone_height}))) begin
            oor <= 1'b1;
            gap <= 32'(One);
          end
        end
        OP_WROT: begin
          wrot[0] <= s32(qm(wa[1], wd[2]) - qm(wa[2], wd[1]));
          wrot[1] <= s32(qm(wa[2], wd[0]) - qm(wa[0], wd[2]));
          wrot[2] <= s32(qm(wa[0], wd[1]) - qm(wa[1], wd[0]));
        end
        OP_SQ: sq <= 64'(64'(wrot[0]) * 64'(wrot[0])) + 64'(64'(wrot[1]) * 64'(wrot[1]))
                     + 64'(64'(wrot[2]) * 64'(wrot[2]));
        OP_SQRT: begin
          if (cmd.start) begin
            busy <= 1'b1;
            cnt <= '0;
            rem <= '0;
            root <= '0;
          end else if (busy) begin
            if (rem_shift >= rt_try) begin
              rem <= rem_shift - rt_try;
              root <= {root[30:0], 1'b1};
            end else begin
              rem <= rem_shift;
              root <= {root[30:0], 1'b0};
            end
            cnt <= cnt + 7'd1;
            if (cnt == 7'd31) busy <= 1'b0;
          end
        end
        OP_UDIV, OP_RH: begin
          if (cmd.start && cmd.op == OP_UDIV) begin
            if (root == '0) begin
              deg <= 1'b1;
            end else begin
              busy <= 1'b1;
              div_rh <= 1'b0;
              lane <= '0;
              cnt <= '0;
              rem <= '0;
              quo <= '0;
              divisor <= {32'd0, root};
              num <= mag64(64'(wrot[0])) << FRAC_BITS;
              quo_neg <= wrot[0] < 0;
            end
          end else if (cmd.start) begin
            // zero height: drop the slope term
            if (cone_height == '0) begin
              rh <= 32'({1'b0, base_radius});
            end else begin
              busy <= 1'b1;
              div_rh <= 1'b1;
              cnt <= '0;
              rem <= '0;
              quo <= '0;
              divisor <= {33'd0, cone_height};
              num <= mag64(rh_prod);
              quo_neg <= rh_prod < 0;
            end
          end else if (busy) begin
            if (cnt != 7'd63) begin
              rem <= dv_try[64] ? {rem[62:0], num[63]} : dv_try[63:0];
              quo <= qlast;
              num <= {num[62:0], 1'b0};
              cnt <= cnt + 7'd1;
            end else begin
              cnt <= '0;
              rem <= '0;
              quo <= '0;
              if (div_rh) begin
                rh <= s32(64'($signed({1'b0, base_radius})) + qsigned);
                busy <= 1'b0;
              end else begin
                u[lane] <= s32(qsigned);
                if (lane == 2'd2) begin
                  busy <= 1'b0;
                end else begin
                  lane <= lane + 2'd1;
                  num <= mag64(64'(wrot[lane + 2'd1])) << FRAC_BITS;
                  quo_neg <= wrot[lane + 2'd1] < 0;
                end
              end
            end
          end
        end
        OP_D: dreg <= s32(qm(wa[0], u[0]) + qm(wa[1], u[1]) + qm(wa[2], u[2]));
        OP_K_W: begin
          kreg <= ksub;
          w[0] <= s32(qm(u[1], wa[2]) - qm(u[2], wa[1]));
          w[1] <= s32(qm(u[2], wa[0]) - qm(u[0], wa[2]));
          w[2] <= s32(qm(u[0], wa[1]) - qm(u[1], wa[0]));
        end
        OP_N: begin
          n_x <= s32(qm(32'(cos_half_angle), wa[0]) + qm(kreg, u[0])
                     + qm(32'(sin_half_angle), w[0]));
          n_y <= s32(qm(32'(cos_half_angle), wa[1]) + qm(kreg, u[1])
                     + qm(32'(sin_half_angle), w[1]));
          n_z <= s32(qm(32'(cos_half_angle), wa[2]) + qm(kreg, u[2])
                     + qm(32'(sin_half_angle), w[2]));
        end
        OP_L: lreg <= s32(qm(wd[0], w[0]) + qm(wd[1], w[1]) + qm(wd[2], w[2]));
        OP_C: for (int i = 0; i < 3; i++) c[i] <= s32(qm(s32(64'(rh) - 64'(lreg)), w[i]));
        OP_GAP: gap <= s32(qm(n_x, c[0]) + qm(n_y, c[1]) + qm(n_z, c[2]));
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pfcg_ctrl.sv -----
module pfcg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_cmd,
  output logic             out_valid,
  input  logic             out_stall,
  output pfcg_pkg::cmd_t   cmd,
  input  pfcg_pkg::stat_t  stat
);
  import pfcg_pkg::*;

  state_t state, state_next;
  logic   started, started_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      started <= 1'b0;
    end else begin
      state <= state_next;
      started <= started_next;
    end
  end

  always_comb begin
    state_next = state;
    started_next = 1'b0;
    case (state)
      S_IDLE: if (accept && in_cmd == CMD_CONTACT) state_next = S_WD;
      S_WD: state_next = S_WA;
      S_WA: state_next = S_LOC;
      S_LOC: state_next = S_WROT;
      S_WROT: state_next = stat.oor ? S_OUT : S_SQ;
      S_SQ: state_next = S_SQRT;
      S_SQRT: begin
        started_next = 1'b1;
        if (started && !stat.busy) begin
          state_next = S_UDIV;
          started_next = 1'b0;
        end
      end
      S_UDIV: begin
        started_next = 1'b1;
        if (stat.deg) begin
          state_next = S_OUT;
        end else if (started && !stat.busy) begin
          state_next = S_D;
          started_next = 1'b0;
        end
      end
      S_D: state_next = S_KW;
      S_KW: state_next = S_N;
      S_N: state_next = S_RH;
      S_RH: begin
        started_next = 1'b1;
        if (started && !stat.busy) begin
          state_next = S_L;
          started_next = 1'b0;
        end
      end
      S_L: state_next = S_C;
      S_C: state_next = S_GAP;
      S_GAP: state_next = S_OUT;
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{op: OP_NONE, start: 1'b0, clr: 1'b0};
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.op = (in_cmd == CMD_LOAD) ? OP_LOAD_ROW : OP_WD;
          cmd.clr = (in_cmd == CMD_CONTACT);
        end
      end
      S_WD: cmd.op = OP_WA;
      S_WA: cmd.op = OP_LOC;
      S_LOC: cmd.op = OP_WROT;
      S_WROT: cmd.op = OP_SQ;
      S_SQ: begin
        cmd.op = OP_SQRT;
        cmd.start = 1'b1;
      end
      S_SQRT: begin
        cmd.op = (started && !stat.busy) ? OP_UDIV : OP_SQRT;
        cmd.start = started && !stat.busy;
      end
      S_UDIV: cmd.op = (started && !stat.busy) ? OP_D : OP_UDIV;
      S_D: cmd.op = OP_K_W;
      S_KW: cmd.op = OP_N;
      S_N: begin
        cmd.op = OP_RH;
        cmd.start = 1'b1;
      end
      S_RH: cmd.op = (started && !stat.busy) ? OP_L : OP_RH;
      S_L: cmd.op = OP_C;
      S_C: cmd.op = OP_GAP;
      S_GAP: cmd.op = OP_NONE;
      S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- rtl/point_frustum_contact_gap.sv -----
// Sequence: a load item writes one matrix row. A contact item skips the root
//   and divides when out of range and the divides when on the axis; else it
//   runs a 32-step root, three 64-step divides for the unit vector and one
//   for the radius slope (none with zero height), all through one shared
//   shift-subtract unit.
// Throughput: one item at a time; stall in is high until the result is taken.
// Reset (synchronous, rst high): config registers, controller state and flags
//   return to their defaults and the orientation matrix clears to zero.
module point_frustum_contact_gap #(
  parameter int FRAC_BITS = pfcg_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [1:0]         row_index,
  input  logic signed [31:0] value_a,
  input  logic signed [31:0] value_b,
  input  logic signed [31:0] value_c,
  input  logic signed [31:0] frustum_x,
  input  logic signed [31:0] frustum_y,
  input  logic signed [31:0] frustum_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] gap,
  output logic signed [18:0] normal_x,
  output logic signed [18:0] normal_y,
  output logic signed [18:0] normal_z,
  output logic               out_of_range,
  output logic               degenerate
);
  import pfcg_pkg::*;

  // Normal outputs clamp to +-2.0, and never beyond the 19-bit range.
  localparam logic signed [31:0] NLim = (2 << FRAC_BITS) > 262143 ? 32'sd262143
                                        : 32'(2 << FRAC_BITS);

  logic signed [31:0] axis_x, axis_y, axis_z;
  logic [30:0] base_radius, top_radius, cone_height;
  logic signed [17:0] cos_half_angle, sin_half_angle;
  logic signed [31:0] n_x, n_y, n_z;
  cmd_t  dcmd;
  stat_t dstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x <= '0;
      axis_y <= '0;
      axis_z <= 32'(1 << FRAC_BITS);
      base_radius <= 31'(1 << FRAC_BITS);
      top_radius <= 31'(1 << FRAC_BITS);
      cone_height <= 31'(1 << FRAC_BITS);
      cos_half_angle <= '0;
      sin_half_angle <= 18'(1 << FRAC_BITS);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_AXIS_X: axis_x <= cfg_data;
        REG_AXIS_Y: axis_y <= cfg_data;
        REG_AXIS_Z: axis_z <= cfg_data;
        REG_BASE_R: base_radius <= cfg_data[30:0];
        REG_TOP_R:  top_radius <= cfg_data[30:0];
        REG_HEIGHT: cone_height <= cfg_data[30:0];
        REG_COS:    cos_half_angle <= cfg_data[17:0];
        REG_SIN:    sin_half_angle <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  pfcg_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_cmd(cmd), .out_valid, .out_stall,
    .cmd(dcmd), .stat(dstat)
  );

  pfcg_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd(dcmd), .stat(dstat), .row_index,
    .value_a, .value_b, .value_c, .frustum_x, .frustum_y, .frustum_z,
    .axis_x, .axis_y, .axis_z, .base_radius, .top_radius, .cone_height,
    .cos_half_angle, .sin_half_angle, .gap, .n_x, .n_y, .n_z
  );

  function automatic logic signed [18:0] nclamp(input logic signed [31:0] v);
    if (v > NLim) return 19'(NLim);
    if (v < -NLim) return 19'(-NLim);
    return 19'(v);
  endfunction

  // Zero the normal on either special case.
  always_comb begin
    normal_x = (dstat.oor || dstat.deg) ? '0 : nclamp(n_x);
    normal_y = (dstat.oor || dstat.deg) ? '0 : nclamp(n_y);
    normal_z = (dstat.oor || dstat.deg) ? '0 : nclamp(n_z);
  end
  assign out_of_range = dstat.oor;
  assign degenerate = dstat.deg;

endmodule

// ----- rtl/pfcg_checker.sv -----
module pfcg_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_of_range,
  input logic degenerate,
  input logic [31:0] gap
);
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_of_range && degenerate)) else $error("both flags set");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(gap)) else $error("result dropped");
  a_deg: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> gap == 32'd0) else $error("degenerate gap nonzero");
endmodule

bind point_frustum_contact_gap pfcg_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_of_range, .degenerate, .gap
);
